/* hw/rtl/sesc_pkg.sv */
// shared types, character codes and decode functions for the string escape encoder
`timescale 1ns / 1ps
package sesc_pkg;

    localparam logic [2:0] MODE_SQ     = 3'd0;
    localparam logic [2:0] MODE_DQ     = 3'd1;
    localparam logic [2:0] MODE_XML    = 3'd2;
    localparam logic [2:0] MODE_BASE64 = 3'd3;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_PAD    = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_SLASH  = 8'h2F;

    localparam logic [47:0] ENT_QUOT = "&quot;";
    localparam logic [39:0] ENT_AMP  = "&amp;";
    localparam logic [31:0] ENT_LT   = "&lt;";
    localparam logic [31:0] ENT_GT   = "&gt;";

    typedef enum logic [3:0] {
        K_PLAIN,
        K_ESC,
        K_QUOT,
        K_AMP,
        K_LT,
        K_GT,
        K_B64_3,
        K_B64_2,
        K_B64_1
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic       last;
    } desc_t;

    function automatic logic [2:0] desc_len(input kind_t k);
        logic [2:0] n;
        unique case (k)
            K_PLAIN: n = 3'd1;
            K_ESC:   n = 3'd2;
            K_QUOT:  n = 3'd6;
            K_AMP:   n = 3'd5;
            K_LT:    n = 3'd4;
            K_GT:    n = 3'd4;
            default: n = 3'd4;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] b64_char(input logic [5:0] s);
        logic [7:0] v;
        priority if (s < 6'd26)
            v = 8'd65 + {2'b00, s};
        else if (s < 6'd52)
            v = 8'd71 + {2'b00, s};
        else if (s < 6'd62)
            v = {2'b00, s} - 8'd4;
        else if (s == 6'd62)
            v = CH_PLUS;
        else
            v = CH_SLASH;
        return v;
    endfunction

    function automatic logic [7:0] char_at(input desc_t d, input logic [2:0] i);
        logic [7:0] ch;
        logic [5:0] sx;
        logic [2:0] nbytes;
        unique case (i[1:0])
            2'd0: sx = d.c0[7:2];
            2'd1: sx = {d.c0[1:0], d.c1[7:4]};
            2'd2: sx = {d.c1[3:0], d.c2[7:6]};
            default: sx = d.c2[5:0];
        endcase
        unique case (d.kind)
            K_B64_3: nbytes = 3'd3;
            K_B64_2: nbytes = 3'd2;
            default: nbytes = 3'd1;
        endcase
        unique case (d.kind)
            K_PLAIN: ch = d.c0;
            K_ESC:   ch = (i == 3'd0) ? CH_BSLASH : d.c0;
            K_QUOT:  ch = ENT_QUOT[8 * (3'd5 - i) +: 8];
            K_AMP:   ch = ENT_AMP[8 * (3'd4 - i) +: 8];
            K_LT:    ch = ENT_LT[8 * (3'd3 - i) +: 8];
            K_GT:    ch = ENT_GT[8 * (3'd3 - i) +: 8];
            default: ch = (i > nbytes) ? CH_PAD : b64_char(sx);
        endcase
        return ch;
    endfunction

endpackage

/* hw/rtl/string_escape_encoder_core.sv */
// top level of the string escape encoder
`timescale 1ns / 1ps
// Takes a string one byte per word (tlast on the final byte) and emits the escaped or
// encoded string one character per word, tlast on its final character. cfg_wr_data selects
// the treatment: 0 backslash before ' and \, 1 backslash before " and \, 2 XML entities for
// " & < >, 3 base64 with '=' padding, 4 to 7 passthrough; a write also drops any partial
// base64 group. The output runs at one character per cycle when the receiver does not stall,
// and an input byte produces as many characters as its treatment gives: one for most bytes, two
// for an escape, four to six for an entity, and in base64 four for the byte that completes a
// group of three or ends the string, none for the other bytes of a group.
// The back end's character sequencer walks through them; a two-entry descriptor queue lets
// input keep flowing while a long expansion or a stalled output is in progress.
module string_escape_encoder_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_wr_data,      // quote_mode
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,     // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,     // [7:0] out_char
    output logic       m_axis_tlast
);
    import sesc_pkg::*;

    logic  in_fire;
    logic  push;
    logic  pop;
    logic  full;
    logic  head_valid;
    desc_t push_desc;
    desc_t head_desc;

    assign s_axis_tready = !full;
    assign in_fire       = s_axis_tvalid && !full;

    sesc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_fire     (in_fire),
        .in_byte     (s_axis_tdata),
        .in_last     (s_axis_tlast),
        .push        (push),
        .push_desc   (push_desc)
    );

    sesc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    sesc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_desc     (head_desc),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* hw/rtl/sesc_front.sv */
// front end: accepts input bytes, holds the mode and base64 group, classifies into descriptors
`timescale 1ns / 1ps
module sesc_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic [2:0]     cfg_wr_data,
    input  logic           in_fire,
    input  logic [7:0]     in_byte,
    input  logic           in_last,
    output logic           push,
    output sesc_pkg::desc_t push_desc
);
    import sesc_pkg::*;

    logic [2:0]  mode_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] held_reg, held_next;
    logic        emit;
    desc_t       d;

    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        emit       = 1'b1;
        d.kind     = K_PLAIN;
        d.c0       = in_byte;
        d.c1       = 8'd0;
        d.c2       = 8'd0;
        d.last     = in_last;
        unique case (mode_reg)
            MODE_SQ:
            begin
                if (in_byte == CH_SQUOTE || in_byte == CH_BSLASH)
                    d.kind = K_ESC;
            end
            MODE_DQ:
            begin
                if (in_byte == CH_DQUOTE || in_byte == CH_BSLASH)
                    d.kind = K_ESC;
            end
            MODE_XML:
            begin
                priority if (in_byte == CH_DQUOTE)
                    d.kind = K_QUOT;
                else if (in_byte == CH_AMP)
                    d.kind = K_AMP;
                else if (in_byte == CH_LT)
                    d.kind = K_LT;
                else if (in_byte == CH_GT)
                    d.kind = K_GT;
                else
                    d.kind = K_PLAIN;
            end
            MODE_BASE64:
            begin
                priority if (phase_reg == 2'd2)
                begin
                    d.kind     = K_B64_3;
                    d.c0       = held_reg[15:8];
                    d.c1       = held_reg[7:0];
                    d.c2       = in_byte;
                    phase_next = 2'd0;
                    held_next  = 16'd0;
                end
                else if (phase_reg == 2'd1)
                begin
                    d.kind = K_B64_2;
                    d.c0   = held_reg[15:8];
                    d.c1   = in_byte;
                    emit   = in_last;
                    if (in_last)
                    begin
                        phase_next = 2'd0;
                        held_next  = 16'd0;
                    end
                    else
                    begin
                        phase_next = 2'd2;
                        held_next  = {held_reg[15:8], in_byte};
                    end
                end
                else
                begin
                    d.kind = K_B64_1;
                    emit   = in_last;
                    if (in_last)
                    begin
                        phase_next = 2'd0;
                        held_next  = 16'd0;
                    end
                    else
                    begin
                        phase_next = 2'd1;
                        held_next  = {in_byte, 8'd0};
                    end
                end
            end
            default:
            begin
                d.kind = K_PLAIN;
            end
        endcase
    end

    assign push      = in_fire && emit;
    assign push_desc = d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_SQ;
            phase_reg <= 2'd0;
            held_reg  <= 16'd0;
        end
        else if (cfg_wr_en)
        begin
            mode_reg  <= cfg_wr_data;
            phase_reg <= 2'd0;
            held_reg  <= 16'd0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

/* hw/rtl/sesc_queue.sv */
// two-entry descriptor queue between front and back
`timescale 1ns / 1ps
module sesc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sesc_pkg::desc_t push_desc,
    input  logic            pop,
    output logic            full,
    output logic            head_valid,
    output sesc_pkg::desc_t head_desc
);
    import sesc_pkg::*;

    desc_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_desc  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

/* hw/rtl/sesc_back.sv */
// back end: expands the head descriptor into one output character per cycle while the output is not stalled
`timescale 1ns / 1ps
module sesc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  sesc_pkg::desc_t head_desc,
    output logic            pop,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [7:0]      m_axis_tdata,
    output logic            m_axis_tlast
);
    import sesc_pkg::*;

    logic [2:0] idx_reg;
    logic       valid_reg;
    logic [7:0] char_reg;
    logic       last_reg;
    logic       step;
    logic       final_char;

    assign step       = head_valid && (!valid_reg || m_axis_tready);
    assign final_char = (idx_reg == desc_len(head_desc.kind) - 3'd1);
    assign pop        = step && final_char;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
                idx_reg <= final_char ? 3'd0 : idx_reg + 3'd1;
            if (step)
                valid_reg <= 1'b1;
            else if (m_axis_tready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            char_reg <= char_at(head_desc, idx_reg);
            last_reg <= head_desc.last && final_char;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = char_reg;
    assign m_axis_tlast  = last_reg;

endmodule

/* hw/rtl/sesc_checker.sv */
// port-level checker for the string escape encoder, bound to the top level
`timescale 1ns / 1ps
module sesc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);
    logic [2:0] pend_reg;
    logic       in_end;
    logic       out_end;

    assign in_end  = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign out_end = m_axis_tvalid && m_axis_tready && m_axis_tlast;

    // strings whose final byte is in but whose final character is not yet out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 3'd0;
        else if (in_end && !out_end)
            pend_reg <= pend_reg + 3'd1;
        else if (out_end && !in_end)
            pend_reg <= pend_reg - 3'd1;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    a_end_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_end |-> (pend_reg != 3'd0 || in_end))
        else $error("string end emitted before its final byte was taken");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
        else $error("output word valid during reset");

endmodule

bind string_escape_encoder_core sesc_checker u_sesc_checker (.*);

/* tb/sv/string_escape_encoder_core_tb.sv */
// self-checking stream testbench for the string escape encoder core
`timescale 1ns / 1ps

import sesc_pkg::*;

typedef struct packed {
    logic [7:0] ch;
    logic       last;
} esc_char_t;

class escape_scoreboard;
    localparam logic [511:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic [2:0]  quote_mode;
    logic [1:0]  group_phase;
    logic [15:0] held_bytes;
    esc_char_t   expected_chars[$];
    esc_char_t   word_chars[$];
    int          mismatches;

    function new();
        quote_mode  = MODE_SQ;
        group_phase = 2'd0;
        held_bytes  = 16'h0000;
        mismatches  = 0;
    endfunction

    // a mode write also drops any partial base64 group
    function void set_mode(logic [2:0] m);
        quote_mode  = m;
        group_phase = 2'd0;
        held_bytes  = 16'h0000;
    endfunction

    function void add_char(logic [7:0] c);
        esc_char_t e;
        e.ch   = c;
        e.last = 1'b0;
        word_chars.push_back(e);
    endfunction

    function void add_sextet(logic [5:0] s);
        int idx;
        idx = 63 - int'(s);
        add_char(B64_ALPHABET[8 * idx +: 8]);
    endfunction

    function void add_text(string t);
        for (int i = 0; i < t.len(); i++)
            add_char(t[i]);
    endfunction

    function void encode_base64(logic [7:0] b, logic last);
        logic [7:0] b0;
        logic [7:0] b1;
        b0 = held_bytes[15:8];
        b1 = held_bytes[7:0];
        if (group_phase >= 2'd2)
        begin
            add_sextet(b0[7:2]);
            add_sextet({b0[1:0], b1[7:4]});
            add_sextet({b1[3:0], b[7:6]});
            add_sextet(b[5:0]);
            group_phase = 2'd0;
            held_bytes  = 16'h0000;
            return;
        end
        if (group_phase == 2'd1)
            held_bytes[7:0] = b;
        else
            held_bytes = {b, 8'h00};
        group_phase = group_phase + 2'd1;
        if (!last)
            return;
        b0 = held_bytes[15:8];
        b1 = held_bytes[7:0];
        add_sextet(b0[7:2]);
        if (group_phase == 2'd2)
        begin
            add_sextet({b0[1:0], b1[7:4]});
            add_sextet({b1[3:0], 2'b00});
        end
        else
        begin
            add_sextet({b0[1:0], 4'b0000});
            add_char(CH_PAD);
        end
        add_char(CH_PAD);
        group_phase = 2'd0;
        held_bytes  = 16'h0000;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
        word_chars.delete();
        case (quote_mode)
            MODE_SQ:
            begin
                if (b == CH_SQUOTE || b == CH_BSLASH)
                    add_char(CH_BSLASH);
                add_char(b);
            end
            MODE_DQ:
            begin
                if (b == CH_DQUOTE || b == CH_BSLASH)
                    add_char(CH_BSLASH);
                add_char(b);
            end
            MODE_XML:
            begin
                if (b == CH_DQUOTE)
                    add_text("&quot;");
                else if (b == CH_AMP)
                    add_text("&amp;");
                else if (b == CH_LT)
                    add_text("&lt;");
                else if (b == CH_GT)
                    add_text("&gt;");
                else
                    add_char(b);
            end
            MODE_BASE64:
                encode_base64(b, last);
            default:
                add_char(b);
        endcase
        if (last && word_chars.size() > 0)
            word_chars[word_chars.size() - 1].last = 1'b1;
        foreach (word_chars[i])
            expected_chars.push_back(word_chars[i]);
    endfunction

    function int pending();
        return expected_chars.size();
    endfunction

    function void check_char(logic [7:0] c, logic last);
        esc_char_t e;
        if (expected_chars.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected output word %h last %b", $realtime, c, last);
            return;
        end
        e = expected_chars.pop_front();
        if (e.ch !== c || e.last !== last)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: output mismatch: expected %h last %b, got %h last %b",
                         $realtime, e.ch, e.last, c, last);
        end
    endfunction
endclass

module string_escape_encoder_core_tb;

    localparam logic [2:0] MODE_PASS       = 3'd4;
    localparam logic [2:0] MODE_UNUSED_TOP = 3'd7;
    localparam int         DRAIN_CYCLES    = 24;
    localparam int         RANDOM_ITEMS    = 360;
    localparam int         TIMEOUT_NS      = 400000;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       cfg_wr_en     = 1'b0;
    logic [2:0] cfg_wr_data   = 3'd0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    escape_scoreboard sb = new();

    int burst_left   = 0;
    int ready_cycles = 0;
    int ready_style  = 0;
    int random_items = 0;

    string_escape_encoder_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver stall pattern, switching at random between four ready styles
    always @(negedge clk)
    begin
        if (ready_cycles == 0)
        begin
            ready_style  <= $urandom_range(0, 3);
            ready_cycles <= $urandom_range(20, 80);
        end
        else
            ready_cycles <= ready_cycles - 1;
        case (ready_style)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            2:       m_axis_tready <= (ready_cycles % 3 == 0);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_byte(s_axis_tdata, s_axis_tlast);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_char(m_axis_tdata, m_axis_tlast);
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 20);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_mode(input logic [2:0] m);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_mode(m);
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] specials [6];
        specials = '{CH_SQUOTE, CH_DQUOTE, CH_BSLASH, CH_AMP, CH_LT, CH_GT};
        if ($urandom_range(0, 9) < 4)
            return specials[$urandom_range(0, 5)];
        return 8'($urandom_range(1, 255));
    endfunction

    initial
    begin
        int         n_strings;
        int         len;
        int         phase_idx;
        logic       cut_short;
        logic [2:0] mode;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: each escaping mode and a passthrough mode, every escaped character, extremes
        write_mode(MODE_SQ);
        send_byte(CH_SQUOTE, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_DQUOTE, 1'b0);
        send_byte(8'hFF, 1'b1);
        s_axis_tvalid <= 1'b0;
        wait_idle();

        write_mode(MODE_DQ);
        send_byte(CH_DQUOTE, 1'b0);
        send_byte(CH_BSLASH, 1'b1);
        s_axis_tvalid <= 1'b0;
        wait_idle();

        // XML: every entity, and a zero byte as an ordinary character
        write_mode(MODE_XML);
        send_byte(CH_DQUOTE, 1'b0);
        send_byte(CH_AMP, 1'b0);
        send_byte(CH_LT, 1'b0);
        send_byte(CH_GT, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h41, 1'b1);
        s_axis_tvalid <= 1'b0;
        wait_idle();

        // base64: one, two and three byte strings, then a byte left in a partial group
        write_mode(MODE_BASE64);
        send_byte(8'h4D, 1'b1);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        s_axis_tvalid <= 1'b0;
        wait_idle();
        // mode write drops the held partial group
        write_mode(MODE_BASE64);
        send_byte(8'h61, 1'b1);
        s_axis_tvalid <= 1'b0;
        wait_idle();

        write_mode(MODE_UNUSED_TOP);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_SQUOTE, 1'b1);
        s_axis_tvalid <= 1'b0;
        wait_idle();

        // random strings, one mode per phase
        phase_idx = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if (phase_idx < 8)
                mode = 3'(phase_idx);
            else if ($urandom_range(0, 3) == 0)
                mode = ($urandom_range(0, 1) == 0) ? MODE_PASS : 3'($urandom_range(5, 7));
            else
                mode = 3'($urandom_range(0, 3));
            phase_idx++;
            write_mode(mode);
            n_strings = $urandom_range(2, 6);
            for (int s = 0; s < n_strings; s++)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30)
                                                  : $urandom_range(1, 10);
                cut_short = (s == n_strings - 1) && ($urandom_range(0, 3) == 0);
                for (int i = 0; i < len; i++)
                begin
                    send_byte(pick_byte(), (i == len - 1) && !cut_short);
                    random_items++;
                end
            end
            s_axis_tvalid <= 1'b0;
            wait_idle();
        end

        if (sb.mismatches == 0)
            $display("string_escape_encoder_core regression: pass");
        else
            $display("string_escape_encoder_core regression: fail");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("string_escape_encoder_core regression: fail");
        $finish;
    end

endmodule
